### rtl/periodic_deadline_scheduler_top_macros.svh
// Assertion macros for the periodic deadline scheduler.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PERIODIC_DEADLINE_SCHEDULER_TOP_MACROS_SVH
`define PERIODIC_DEADLINE_SCHEDULER_TOP_MACROS_SVH

// Consequence must hold in the same cycle as the condition.
`define PDS_ASSERT_SAME(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Consequence must hold in the cycle after the condition.
`define PDS_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

### rtl/pds_pkg.sv
// Shared types, widths and codes for the periodic deadline scheduler.
// No dependencies; imported by every module of the block.
package pds_pkg;

	localparam int MaxCh    = 4;
	localparam int TimeW    = 63;
	localparam int PeriodW  = 30;
	localparam int ExecW    = 32;
	localparam int TickW    = 32;
	localparam int ChW      = 2;
	localparam int CmdW     = 2;
	localparam int ActW     = 3;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 30;
	localparam int QDepth   = 2;
	localparam int QPtrW    = $clog2(QDepth);
	localparam int QCntW    = $clog2(QDepth + 1);

	// Input command codes
	localparam logic [CmdW-1:0] CmdStart  = 2'd0;
	localparam logic [CmdW-1:0] CmdTick   = 2'd1;
	localparam logic [CmdW-1:0] CmdReport = 2'd2;
	localparam logic [CmdW-1:0] CmdUnused = 2'd3;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgPeriod0 = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgPeriod1 = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgPeriod2 = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgPeriod3 = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgActive  = 3'd4;

	// Result kinds
	localparam logic KindFire    = 1'b0;
	localparam logic KindVerdict = 1'b1;

	localparam logic [PeriodW-1:0] PeriodReset = 30'd1000000;

	typedef enum logic [1:0] {
		OP_START,
		OP_TICK,
		OP_REPORT
	} op_t;

	// One classified command waiting in the queue
	typedef struct packed {
		op_t              op;
		logic [TimeW-1:0] time_now;
		logic [ChW-1:0]   channel;
		logic             present;
		logic [ExecW-1:0] exec_time;
	} q_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WALK
	} back_state_t;

	// Deadline sum that saturates at the largest 63-bit value
	function automatic logic [TimeW-1:0] sat_add63(input logic [TimeW-1:0] a,
			input logic [PeriodW-1:0] b);
		logic [TimeW:0] s;
		s = {1'b0, a} + (TimeW + 1)'(b);
		return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
	endfunction

endpackage

### rtl/periodic_deadline_scheduler_top.sv
// Top level of the periodic deadline scheduler: configuration registers,
// front end queue and back end executor. Depends on pds_pkg, pds_front, pds_back.
//
// Usage:
// - Request channel (req_valid/req_ready): cmd start arms every channel at
//   time_now plus its period and clears the tick counter; tick checks the
//   first active_count channels; report judges exec_time against a period.
//   cmd 3 is taken and dropped.
// - Result channel (res_valid/res_ready): one transfer per fired channel or
//   verdict, last marks the final result of a command.
// - Configuration (cfg_we/cfg_index/cfg_data): periods 0..3, then
//   active_count; write only while the block is idle.
// - A two-entry queue sits between the front end and the executor, so
//   requests keep flowing while a result waits in the output register.
// - Executor: start and report are handled straight from the idle state; a
//   tick latches its time, scans for due channels, then walks them one
//   channel per cycle, lowest first, while the output register is free.
// - A stalled receiver holds the output register and the executor waits;
//   the queue then fills and req_ready drops.
// - Reset clears deadlines, the tick counter, the queue and sets periods to
//   1000000 ns and active_count to 0.
`include "periodic_deadline_scheduler_top_macros.svh"

module periodic_deadline_scheduler_top import pds_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [CmdW-1:0]     cmd,
	input  logic [TimeW-1:0]    time_now,
	input  logic [ChW-1:0]      report_channel,
	input  logic [ExecW-1:0]    exec_time,
	output logic                res_valid,
	input  logic                res_ready,
	output logic                kind,
	output logic [ChW-1:0]      channel,
	output logic [TimeW-1:0]    lateness,
	output logic [TickW-1:0]    tick_number,
	output logic                overrun,
	output logic                last
);

	logic [PeriodW-1:0] period_q [MaxCh];
	logic [ActW-1:0]    active_count_q;
	logic               q_valid;
	q_item_t            q_item;
	logic               q_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxCh; i++) begin
				period_q[i] <= PeriodReset;
			end
			active_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgPeriod0: period_q[0]    <= cfg_data[PeriodW-1:0];
				CfgPeriod1: period_q[1]    <= cfg_data[PeriodW-1:0];
				CfgPeriod2: period_q[2]    <= cfg_data[PeriodW-1:0];
				CfgPeriod3: period_q[3]    <= cfg_data[PeriodW-1:0];
				CfgActive:  active_count_q <= cfg_data[ActW-1:0];
				default: begin
				end
			endcase
		end
	end

	pds_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.cmd            (cmd),
		.time_now       (time_now),
		.report_channel (report_channel),
		.exec_time      (exec_time),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	pds_back #(
		.CHANNELS(CHANNELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.period       (period_q),
		.active_count (active_count_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.kind         (kind),
		.channel      (channel),
		.lateness     (lateness),
		.tick_number  (tick_number),
		.overrun      (overrun),
		.last         (last)
	);

	// A queued command is visible to the executor the cycle after its transfer
	`PDS_ASSERT_NEXT(a_push_visible, req_valid && req_ready && (cmd != CmdUnused), q_valid, "queued command not visible")
	// A verdict is always a single, final result with cleared timing fields
	`PDS_ASSERT_SAME(a_verdict_form, res_valid && (kind == KindVerdict), last && (lateness == '0) && (tick_number == '0), "malformed verdict")
	// A fire never carries an overrun flag
	`PDS_ASSERT_SAME(a_fire_no_ovr, res_valid && (kind == KindFire), !overrun, "overrun set on fire")

endmodule

### rtl/pds_front.sv
// Front end: accepts input transfers, classifies commands, queues them.
// Depends on pds_pkg.
module pds_front import pds_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [CmdW-1:0]  cmd,
	input  logic [TimeW-1:0] time_now,
	input  logic [ChW-1:0]   report_channel,
	input  logic [ExecW-1:0] exec_time,
	output logic             q_valid,
	output q_item_t          q_item,
	input  logic             q_pop
);

	q_item_t           q_mem_q [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q;
	logic [QPtrW-1:0]  rd_ptr_q;
	logic [QCntW-1:0]  count_q;
	q_item_t           new_item;
	logic              push;

	// Classify the incoming command; unused codes are dropped
	always_comb begin
		new_item.time_now  = time_now;
		new_item.channel   = report_channel;
		new_item.present   = ({1'b0, report_channel} < ActW'(CHANNELS));
		new_item.exec_time = exec_time;
		unique case (cmd)
			CmdStart: new_item.op = OP_START;
			CmdTick:  new_item.op = OP_TICK;
			default:  new_item.op = OP_REPORT;
		endcase
	end

	assign req_ready = (count_q != QCntW'(QDepth));
	assign push      = req_valid && req_ready && (cmd != CmdUnused);
	assign q_valid   = (count_q != '0);
	assign q_item    = q_mem_q[rd_ptr_q];

	// Store queue entries
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + QCntW'(1);
			end else if (q_pop && !push) begin
				count_q <= count_q - QCntW'(1);
			end
		end
	end

endmodule

### rtl/pds_back.sv
// Back end: executes queued commands against the deadline state and
// drives the result register. Depends on pds_pkg.
module pds_back import pds_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [PeriodW-1:0] period [MaxCh],
	input  logic [ActW-1:0]    active_count,
	input  logic               q_valid,
	input  q_item_t            q_item,
	output logic               q_pop,
	output logic               res_valid,
	input  logic               res_ready,
	output logic               kind,
	output logic [ChW-1:0]     channel,
	output logic [TimeW-1:0]   lateness,
	output logic [TickW-1:0]   tick_number,
	output logic               overrun,
	output logic               last
);

	back_state_t         state_q, state_d;
	logic [TimeW-1:0]    deadline_q [CHANNELS];
	logic [TickW-1:0]    tick_count_q;
	logic [TimeW-1:0]    now_q;
	logic [CHANNELS-1:0] due_q;

	logic                res_valid_q;
	logic                kind_q;
	logic [ChW-1:0]      channel_q;
	logic [TimeW-1:0]    lateness_q;
	logic [TickW-1:0]    tick_number_q;
	logic                overrun_q;
	logic                last_q;

	logic [ActW-1:0]     act_lim;
	logic [CHANNELS-1:0] due_new;
	logic [CHANNELS-1:0] sel_oh;
	logic [CHANNELS-1:0] remain;
	logic [TimeW-1:0]    sel_d;
	logic [PeriodW-1:0]  sel_p;
	logic [ChW-1:0]      sel_ch;
	logic [TimeW-1:0]    step_d;
	logic [TimeW-1:0]    catch_d;
	logic [TimeW-1:0]    upd_d;
	logic                out_free;
	logic                verdict_ovr;

	logic                arm;
	logic                ld_now;
	logic                ld_due;
	logic                emit_fire;
	logic                emit_verdict;
	logic                tick_inc;

	// Due mask over the active channels at the latched tick time
	always_comb begin
		act_lim = (active_count > ActW'(CHANNELS)) ? ActW'(CHANNELS) : active_count;
		for (int i = 0; i < CHANNELS; i++) begin
			due_new[i] = (ActW'(i) < act_lim) && (now_q >= deadline_q[i]);
		end
	end

	// Pick the lowest due channel and compute its new deadline
	always_comb begin
		sel_oh = due_q & (~due_q + CHANNELS'(1));
		remain = due_q & ~sel_oh;
		sel_d  = '0;
		sel_p  = '0;
		sel_ch = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (sel_oh[i]) begin
				sel_d  = sel_d | deadline_q[i];
				sel_p  = sel_p | period[i];
				sel_ch = sel_ch | ChW'(i);
			end
		end
		step_d  = sat_add63(sel_d, sel_p);
		catch_d = sat_add63(now_q, sel_p);
		upd_d   = (step_d < now_q) ? catch_d : step_d;
	end

	assign out_free    = !res_valid_q || res_ready;
	assign verdict_ovr = q_item.present && (q_item.exec_time > ExecW'(period[q_item.channel]));

	// Sequencer: next state and strobes
	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		arm          = 1'b0;
		ld_now       = 1'b0;
		ld_due       = 1'b0;
		emit_fire    = 1'b0;
		emit_verdict = 1'b0;
		tick_inc     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_item.op)
						OP_START: begin
							arm   = 1'b1;
							q_pop = 1'b1;
						end
						OP_TICK: begin
							ld_now  = 1'b1;
							q_pop   = 1'b1;
							state_d = ST_SCAN;
						end
						OP_REPORT: begin
							if (out_free) begin
								emit_verdict = 1'b1;
								q_pop        = 1'b1;
							end
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				ld_due = 1'b1;
				if (due_new == '0) begin
					tick_inc = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (out_free) begin
					emit_fire = 1'b1;
					if (remain == '0) begin
						tick_inc = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Deadlines: arm all on start, advance the firing channel on a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				deadline_q[i] <= '0;
			end
			tick_count_q <= '0;
			due_q        <= '0;
		end else begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (arm) begin
					deadline_q[i] <= sat_add63(q_item.time_now, period[i]);
				end else if (emit_fire && sel_oh[i]) begin
					deadline_q[i] <= upd_d;
				end
			end
			if (arm) begin
				tick_count_q <= '0;
			end else if (tick_inc) begin
				tick_count_q <= tick_count_q + TickW'(1);
			end
			if (ld_due) begin
				due_q <= due_new;
			end else if (emit_fire) begin
				due_q <= remain;
			end
		end
	end

	// Hold the tick time for the walk
	always_ff @(posedge clk) begin
		if (ld_now) begin
			now_q <= q_item.time_now;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_fire || emit_verdict) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			kind_q        <= KindFire;
			channel_q     <= sel_ch;
			lateness_q    <= now_q - sel_d;
			tick_number_q <= tick_count_q;
			overrun_q     <= 1'b0;
			last_q        <= (remain == '0);
		end else if (emit_verdict) begin
			kind_q        <= KindVerdict;
			channel_q     <= q_item.channel;
			lateness_q    <= '0;
			tick_number_q <= '0;
			overrun_q     <= verdict_ovr;
			last_q        <= 1'b1;
		end
	end

	assign res_valid   = res_valid_q;
	assign kind        = kind_q;
	assign channel     = channel_q;
	assign lateness    = lateness_q;
	assign tick_number = tick_number_q;
	assign overrun     = overrun_q;
	assign last        = last_q;

endmodule
